[hdl/assert_macros.svh]
// Concurrent assertion helpers; the enclosing module supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/rpn_pkg.sv]
package rpn_pkg;

	localparam logic [2:0] OP_PUSH = 3'd0;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;
	localparam logic [2:0] OP_DUMP = 3'd5;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_UNDER = 2'd1;
	localparam logic [1:0] STS_OVER  = 2'd2;
	localparam logic [1:0] STS_DIVZ  = 2'd3;

	localparam int DIV_BITS = 32;

	typedef struct packed {
		logic [2:0]  op;
		logic [30:0] literal;
	} tok_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               printed;
		logic signed [31:0] value;
	} res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EXEC,
		S_DIV,
		S_SIGN,
		S_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic exec;
		logic div_step;
		logic div_sign;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
	} dp_sts_t;

endpackage

[hdl/rpn_datapath.sv]
module rpn_datapath #(
	parameter int STACK_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rpn_pkg::tok_t    in_data,
	output rpn_pkg::res_t    out_data,
	input  rpn_pkg::dp_cmd_t cmd,
	output rpn_pkg::dp_sts_t sts
);
	import rpn_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [31:0]   mem [STACK_DEPTH];
	tok_t          tok_q;
	logic [CW-1:0] cnt_q;
	logic [31:0]   rd_r_q;
	logic [31:0]   rd_l_q;
	logic [1:0]    sts_q;
	logic          prt_q;
	logic [31:0]   val_q;
	res_t          out_q;
	logic [31:0]   rem_q;
	logic [31:0]   quo_q;
	logic [31:0]   dvs_q;
	logic          neg_q;
	logic [4:0]    step_q;

	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_m2;
	logic [AW-1:0] addr_top;
	logic [AW-1:0] addr_next;
	logic          empty;
	logic          lt2;
	logic          full;
	logic          is_arith;
	logic          is_push;
	logic          ok;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_data;
	logic [1:0]    ex_sts;
	logic          ex_prt;
	logic [31:0]   ex_val;
	logic          need_div;
	logic [31:0]   prod;
	logic [32:0]   trial;

	assign cnt_m1    = cnt_q - CW'(1);
	assign cnt_m2    = cnt_q - CW'(2);
	assign addr_top  = cnt_m1[AW-1:0];
	assign addr_next = cnt_m2[AW-1:0];
	assign empty     = (cnt_q == '0);
	assign lt2       = (cnt_q < CW'(2));
	assign full      = (cnt_q == CW'(STACK_DEPTH));
	assign is_push   = (tok_q.op == OP_PUSH);
	assign is_arith  = (tok_q.op == OP_ADD) || (tok_q.op == OP_SUB) ||
		(tok_q.op == OP_MUL) || (tok_q.op == OP_DIV);
	assign prod      = rd_l_q * rd_r_q;

	always_comb begin
		ex_sts   = STS_OK;
		ex_prt   = 1'b0;
		ex_val   = '0;
		need_div = 1'b0;
		unique case (tok_q.op)
			OP_PUSH: begin
				if (full) begin
					ex_sts = STS_OVER;
				end else begin
					ex_val = {1'b0, tok_q.literal};
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
				if (lt2) begin
					ex_sts = STS_UNDER;
				end else if (tok_q.op == OP_DIV) begin
					if (rd_r_q == '0) begin
						ex_sts = STS_DIVZ;
					end else begin
						need_div = 1'b1;
					end
				end else if (tok_q.op == OP_ADD) begin
					ex_val = rd_l_q + rd_r_q;
				end else if (tok_q.op == OP_SUB) begin
					ex_val = rd_l_q - rd_r_q;
				end else begin
					ex_val = prod;
				end
			end
			OP_DUMP: begin
				if (empty) begin
					ex_sts = STS_UNDER;
				end else begin
					ex_val = rd_r_q;
					ex_prt = 1'b1;
				end
			end
			default: begin
				ex_val = empty ? '0 : rd_r_q;
			end
		endcase
	end

	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	assign ok      = (sts_q == STS_OK);
	assign wr_en   = cmd.commit && ok && (is_push || is_arith);
	assign wr_addr = is_push ? cnt_q[AW-1:0] : addr_next;
	assign wr_data = is_push ? {1'b0, tok_q.literal} : val_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			rd_r_q <= mem[addr_top];
			rd_l_q <= mem[addr_next];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tok_q <= in_data;
		end
		if (cmd.exec) begin
			sts_q <= ex_sts;
			prt_q <= ex_prt;
			val_q <= ex_val;
			rem_q <= '0;
			quo_q <= rd_l_q[31] ? (32'd0 - rd_l_q) : rd_l_q;
			dvs_q <= rd_r_q[31] ? (32'd0 - rd_r_q) : rd_r_q;
			neg_q <= rd_l_q[31] ^ rd_r_q[31];
		end
		if (cmd.div_step) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
		if (cmd.div_sign) begin
			val_q <= neg_q ? (32'd0 - quo_q) : quo_q;
		end
		if (cmd.commit) begin
			out_q <= '{status: sts_q, printed: prt_q, value: val_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			step_q <= '0;
		end else begin
			if (cmd.exec) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + 5'd1;
			end
			if (cmd.commit && ok) begin
				if (is_push) begin
					cnt_q <= cnt_q + CW'(1);
				end else if (is_arith || (tok_q.op == OP_DUMP)) begin
					cnt_q <= cnt_m1;
				end
			end
		end
	end

	assign sts.need_div = need_div;
	assign sts.div_last = (step_q == 5'(DIV_BITS - 1));
	assign out_data     = out_q;

endmodule

[hdl/rpn_ctrl.sv]
`include "assert_macros.svh"

module rpn_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output rpn_pkg::dp_cmd_t cmd,
	input  rpn_pkg::dp_sts_t sts
);
	import rpn_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.need_div ? S_DIV : S_FIN;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_SIGN;
				end
			end
			S_SIGN: begin
				cmd.div_sign = 1'b1;
				state_d      = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	`ASSERT_IMP(a_commit_free, cmd.commit, !out_valid_q || out_ready, "result overwritten")
	`ASSERT_NXT(a_accept_read, in_valid && in_ready, state_q == S_READ, "accept not followed by read")
	`ASSERT_NXT(a_div_sign, state_q == S_DIV && sts.div_last, state_q == S_SIGN, "divide overran")

endmodule

[hdl/rpn_stack_evaluator_core.sv]
// Reverse-Polish integer calculator. Each token (push, add, subtract, multiply, divide, dump)
// gives one result with a status. The operand stack is a single memory with one write port and
// two registered read ports; entries are never cleared, so no start-up pass is needed. Push,
// dump, add, subtract, multiply and unused codes pass through the accept, stack read, execute
// and commit steps, the result being registered at commit; divide adds, between execute and
// commit, the radix-2 divider, which resolves one quotient bit per cycle for a 32-bit quotient,
// and a sign fix-up step. The next token is accepted while a result still waits at the output;
// its commit then holds until that result leaves.
module rpn_stack_evaluator_core #(
	parameter int STACK_DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rpn_pkg::tok_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output rpn_pkg::res_t out_data
);
	import rpn_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	rpn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	rpn_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.out_data (out_data),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
	import rpn_pkg::*;

	localparam int DEPTH = 64;
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;
	localparam int MODE_MIX = 0;
	localparam int MODE_PUSHY = 1;
	localparam int MODE_DRAIN = 2;
	localparam int FILL_ITEMS = 70;
	localparam int RANDOM_ITEMS = 1780;
	localparam int QUIET_ITEMS = 200;

	typedef struct {
		tok_t tok;
		bit   typed;
		res_t fixed;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	tok_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	res_t out_data;

	logic [31:0] calc_stack [DEPTH];
	int calc_depth = 0;
	res_t expected_results [$];
	dir_row_t directed_rows [$];
	int mismatch_count = 0;
	bit quiet = 1'b0;
	int idle_pct = 0;
	int stall_pct = 0;
	int stall_left = 0;
	res_t want_res;

	rpn_stack_evaluator_core #(.STACK_DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] quotient_trunc(input logic [31:0] l, input logic [31:0] r);
		logic [31:0] lm;
		logic [31:0] rm;
		logic [31:0] q;
		lm = l[31] ? (32'd0 - l) : l;
		rm = r[31] ? (32'd0 - r) : r;
		q = lm / rm;
		return (l[31] ^ r[31]) ? (32'd0 - q) : q;
	endfunction

	function automatic res_t rpn_evaluate(input tok_t t);
		res_t res;
		logic [31:0] lhs;
		logic [31:0] rhs;
		logic [31:0] acc;
		res = '0;
		res.status = STS_OK;
		case (t.op)
			OP_PUSH: begin
				if (calc_depth >= DEPTH) begin
					res.status = STS_OVER;
				end else begin
					calc_stack[calc_depth] = {1'b0, t.literal};
					calc_depth++;
					res.value = {1'b0, t.literal};
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
				if (calc_depth < 2) begin
					res.status = STS_UNDER;
				end else begin
					rhs = calc_stack[calc_depth - 1];
					lhs = calc_stack[calc_depth - 2];
					acc = '0;
					case (t.op)
						OP_ADD: acc = lhs + rhs;
						OP_SUB: acc = lhs - rhs;
						OP_MUL: acc = lhs * rhs;
						default: if (rhs != 0) acc = quotient_trunc(lhs, rhs);
					endcase
					if (t.op == OP_DIV && rhs == 0) begin
						res.status = STS_DIVZ;
					end else begin
						calc_depth--;
						calc_stack[calc_depth - 1] = acc;
						res.value = acc;
					end
				end
			end
			OP_DUMP: begin
				if (calc_depth == 0) begin
					res.status = STS_UNDER;
				end else begin
					calc_depth--;
					res.value = calc_stack[calc_depth];
					res.printed = 1'b1;
				end
			end
			default: if (calc_depth != 0) res.value = calc_stack[calc_depth - 1];
		endcase
		return res;
	endfunction

	function automatic logic [30:0] pick_literal();
		logic [31:0] r32;
		r32 = $urandom();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 31'($urandom_range(0, 15));
			4: return '0;
			5: return 31'h7FFF_FFFF;
			6: return 31'd1;
			default: return r32[30:0];
		endcase
	endfunction

	function automatic tok_t pick_token(input int mode);
		tok_t t;
		int p;
		int push_lim;
		int arith_lim;
		int dump_lim;
		p = $urandom_range(0, 99);
		case (mode)
			MODE_PUSHY: begin
				push_lim = 85; arith_lim = 93; dump_lim = 98;
			end
			MODE_DRAIN: begin
				push_lim = 15; arith_lim = 60; dump_lim = 97;
			end
			default: begin
				push_lim = 45; arith_lim = 85; dump_lim = 96;
			end
		endcase
		t.literal = pick_literal();
		if (p < push_lim)
			t.op = OP_PUSH;
		else if (p < arith_lim)
			t.op = 3'($urandom_range(OP_ADD, OP_DIV));
		else if (p < dump_lim)
			t.op = OP_DUMP;
		else
			t.op = $urandom_range(0, 1) ? OP_SPARE7 : OP_SPARE6;
		return t;
	endfunction

	function automatic void add_row(input logic [2:0] op, input logic [30:0] lit, input bit typed,
			input logic [1:0] st, input logic pr, input logic [31:0] val);
		dir_row_t r;
		r.tok.op = op;
		r.tok.literal = lit;
		r.typed = typed;
		r.fixed.status = st;
		r.fixed.printed = pr;
		r.fixed.value = val;
		directed_rows.insert(directed_rows.size(), r);
	endfunction

	task automatic send_token(input tok_t t, input bit typed, input res_t fixed);
		res_t pred;
		if (!quiet && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= t;
		do @(posedge clk); while (!in_ready);
		pred = rpn_evaluate(t);
		expected_results.insert(expected_results.size(), typed ? fixed : pred);
	endtask

	task automatic note_mismatch(input string what, input res_t want, input res_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t %s: expected %0d/%0d/%0d, got %0d/%0d/%0d (status/printed/value)",
				$realtime, what, want.status, want.printed, want.value,
				got.status, got.printed, got.value);
	endtask

	// hold out_ready low in bursts, rerolling the stall rate now and then
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
		end else begin
			if ($urandom_range(0, 63) == 0)
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 6;
					default: stall_pct = 30;
				endcase
			if (!quiet && $urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(0, 16);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				note_mismatch("result transaction with none pending", '0, out_data);
			end else begin
				want_res = expected_results.pop_front();
				if (out_data.status !== want_res.status || out_data.printed !== want_res.printed ||
						out_data.value !== want_res.value)
					note_mismatch("result mismatch", want_res, out_data);
			end
		end
	end

	initial begin
		int sent;
		int seg_len;
		int mode;
		int k;

		add_row(OP_DUMP,   31'h7FFF_FFFF, 1'b1, STS_UNDER, 1'b0, 32'd0);
		add_row(OP_ADD,    31'd0,         1'b1, STS_UNDER, 1'b0, 32'd0);
		add_row(OP_SPARE6, 31'h5555_5555, 1'b1, STS_OK,    1'b0, 32'd0);
		add_row(OP_PUSH,   31'h7FFF_FFFF, 1'b1, STS_OK,    1'b0, 32'h7FFF_FFFF);
		add_row(OP_SUB,    31'd0,         1'b1, STS_UNDER, 1'b0, 32'd0);
		add_row(OP_MUL,    31'd9,         1'b1, STS_UNDER, 1'b0, 32'd0);
		add_row(OP_DIV,    31'd0,         1'b1, STS_UNDER, 1'b0, 32'd0);
		add_row(OP_PUSH,   31'd0,         1'b1, STS_OK,    1'b0, 32'd0);
		add_row(OP_DIV,    31'h7FFF_FFFF, 1'b1, STS_DIVZ,  1'b0, 32'd0);
		add_row(OP_SPARE7, 31'h2AAA_AAAA, 1'b1, STS_OK,    1'b0, 32'd0);
		add_row(OP_PUSH,   31'd1,         1'b1, STS_OK,    1'b0, 32'd1);
		add_row(OP_ADD,    31'h1234_5678, 1'b0, STS_OK,    1'b0, 32'd0);
		add_row(OP_ADD,    31'd0,         1'b0, STS_OK,    1'b0, 32'd0);
		add_row(OP_PUSH,   31'd0,         1'b0, STS_OK,    1'b0, 32'd0);
		add_row(OP_PUSH,   31'd1,         1'b0, STS_OK,    1'b0, 32'd0);
		add_row(OP_SUB,    31'd0,         1'b0, STS_OK,    1'b0, 32'd0);
		add_row(OP_DIV,    31'd0,         1'b0, STS_OK,    1'b0, 32'd0);
		add_row(OP_PUSH,   31'd7,         1'b0, STS_OK,    1'b0, 32'd0);
		add_row(OP_MUL,    31'd0,         1'b0, STS_OK,    1'b0, 32'd0);
		add_row(OP_PUSH,   31'd3,         1'b0, STS_OK,    1'b0, 32'd0);
		add_row(OP_DIV,    31'd0,         1'b0, STS_OK,    1'b0, 32'd0);
		add_row(OP_DUMP,   31'd0,         1'b0, STS_OK,    1'b0, 32'd0);
		add_row(OP_DUMP,   31'd0,         1'b1, STS_UNDER, 1'b0, 32'd0);
		add_row(OP_PUSH,   31'h7FFF_FFFF, 1'b1, STS_OK,    1'b0, 32'h7FFF_FFFF);
		add_row(OP_PUSH,   31'h7FFF_FFFF, 1'b1, STS_OK,    1'b0, 32'h7FFF_FFFF);
		add_row(OP_MUL,    31'h7FFF_FFFF, 1'b0, STS_OK,    1'b0, 32'd0);
		add_row(OP_DUMP,   31'd0,         1'b0, STS_OK,    1'b0, 32'd0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_token(directed_rows[i].tok, directed_rows[i].typed, directed_rows[i].fixed);

		// fill past the top of the stack to reach overflow
		idle_pct = 10;
		for (k = 0; k < FILL_ITEMS; k++)
			send_token('{op: OP_PUSH, literal: pick_literal()}, 1'b0, '0);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			seg_len = $urandom_range(20, 120);
			case ($urandom_range(0, 3))
				0, 1: mode = MODE_MIX;
				2: mode = MODE_PUSHY;
				default: mode = MODE_DRAIN;
			endcase
			case ($urandom_range(0, 2))
				0: idle_pct = 0;
				1: idle_pct = 8;
				default: idle_pct = 35;
			endcase
			for (k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
				if (sent == RANDOM_ITEMS - QUIET_ITEMS)
					quiet = 1'b1;
				send_token(pick_token(mode), 1'b0, '0);
				sent++;
			end
		end
		in_valid <= 1'b0;

		while (expected_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("rpn_stack_evaluator_core verification clean");
		else
			$display("rpn_stack_evaluator_core verification failed");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("rpn_stack_evaluator_core verification failed");
		$finish;
	end

endmodule
